// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DHT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DHT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- hdl/dht_pkg.sv -----
// Types and constants for the decimal/hex text to integer parser.
package dht_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [7:0] CHAR_LO_X  = 8'h78;
  localparam logic [7:0] CHAR_UP_X  = 8'h58;

  localparam logic [3:0] DEC_LIMIT  = 4'd10;
  localparam logic [3:0] HEX_LIMIT  = 4'd8;
  localparam logic [3:0] CNT_MAX    = 4'd15;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_LATER  = 2'd2;

  // Classification of one character.
  typedef struct packed {
    logic       is_end;     // end flag or NUL character
    logic       is_x;       // 'x' or 'X'
    logic       is_zero;    // '0'
    logic       dec_ok;     // '0'..'9'
    logic       hex_ok;     // '0'..'9', 'a'..'f', 'A'..'F'
    logic [3:0] digit;      // digit value, valid when hex_ok
  } dht_char_t;

endpackage

// ----- hdl/dht_char_decode.sv -----
// Character classifier: end detection, prefix letter and digit value.
module dht_char_decode
  import dht_pkg::*;
(
  input  logic [7:0] text_char_i,
  input  logic       end_of_text_i,
  output dht_char_t  class_o
);

  logic       is_dec;
  logic       is_lo;
  logic       is_up;
  logic [3:0] dec_off;
  logic [3:0] lo_off;
  logic [3:0] up_off;

  assign is_dec  = (text_char_i >= CHAR_0)    && (text_char_i <= CHAR_9);
  assign is_lo   = (text_char_i >= CHAR_LO_A) && (text_char_i <= CHAR_LO_F);
  assign is_up   = (text_char_i >= CHAR_UP_A) && (text_char_i <= CHAR_UP_F);
  // low nibble of the difference only needs the low nibbles
  assign dec_off = text_char_i[3:0] - CHAR_0[3:0];
  assign lo_off  = text_char_i[3:0] - CHAR_LO_A[3:0];
  assign up_off  = text_char_i[3:0] - CHAR_UP_A[3:0];

  always_comb begin
    class_o.is_end  = end_of_text_i || (text_char_i == CHAR_NUL);
    class_o.is_x    = (text_char_i == CHAR_LO_X) || (text_char_i == CHAR_UP_X);
    class_o.is_zero = (text_char_i == CHAR_0);
    class_o.dec_ok  = is_dec;
    class_o.hex_ok  = is_dec || is_lo || is_up;
    if (is_dec) begin
      class_o.digit = dec_off;
    end else if (is_lo) begin
      class_o.digit = lo_off + 4'd10;
    end else begin
      class_o.digit = up_off + 4'd10;
    end
  end

endmodule

// ----- hdl/dht_parse_core.sv -----
// Parser state: accumulator, digit count, prefix tracking and result logic.
module dht_parse_core
  import dht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  dht_char_t   item_i,
  output logic [31:0] value_o,
  output logic        error_o
);

  logic [31:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [1:0]  pos_q, pos_d;
  logic        first_zero_q, first_zero_d;
  logic        hex_q, hex_d;
  logic        bad_q, bad_d;

  logic        digit_ok;
  logic        prefix;
  logic        too_long;
  logic [31:0] acc_dec;
  logic [31:0] acc_hex;

  assign digit_ok = hex_q ? item_i.hex_ok : item_i.dec_ok;
  assign prefix   = (pos_q == POS_SECOND) && first_zero_q && !hex_q && item_i.is_x;
  // acc * 10 + d as two shifted copies plus the digit
  assign acc_dec  = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, item_i.digit};
  assign acc_hex  = {acc_q[27:0], item_i.digit};

  assign too_long = cnt_q > (hex_q ? HEX_LIMIT : DEC_LIMIT);
  assign value_o  = too_long ? 32'd0 : acc_q;
  assign error_o  = too_long || bad_q;

  always_comb begin
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    first_zero_d = first_zero_q;
    hex_d        = hex_q;
    bad_d        = bad_q;
    if (step_i) begin
      if (item_i.is_end) begin
        acc_d        = '0;
        cnt_d        = '0;
        pos_d        = POS_FIRST;
        first_zero_d = 1'b0;
        hex_d        = 1'b0;
        bad_d        = 1'b0;
      end else if (prefix) begin
        hex_d = 1'b1;
        acc_d = '0;
        cnt_d = '0;
        bad_d = 1'b0;
        pos_d = POS_LATER;
      end else begin
        if (cnt_q != CNT_MAX) begin
          cnt_d = cnt_q + 4'd1;
        end
        if (!bad_q) begin
          if (!digit_ok) begin
            bad_d = 1'b1;
          end else if (hex_q) begin
            acc_d = acc_hex;
          end else begin
            acc_d = acc_dec;
          end
        end
        if (pos_q == POS_FIRST) begin
          first_zero_d = item_i.is_zero;
        end
        if (pos_q != POS_LATER) begin
          pos_d = pos_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      cnt_q        <= '0;
      pos_q        <= POS_FIRST;
      first_zero_q <= 1'b0;
      hex_q        <= 1'b0;
      bad_q        <= 1'b0;
    end else begin
      acc_q        <= acc_d;
      cnt_q        <= cnt_d;
      pos_q        <= pos_d;
      first_zero_q <= first_zero_d;
      hex_q        <= hex_d;
      bad_q        <= bad_d;
    end
  end

endmodule

// ----- hdl/decimal_hex_text_to_integer_unit.sv -----
// Streaming parser of decimal or 0x-prefixed hex text into a 32-bit unsigned value.
// Takes one character per cycle while the input is not stalled, with no gaps between
// strings. Each transfer lands in an input register; from there it updates the parser
// state (a shift-add multiply by ten or a 4-bit shift) and, for an end item or a NUL
// character, loads the value and error flag into the output register, so a result
// passes through the input register and then the output register. Input stall is
// raised only when an end item sits in the input register while the output register
// still holds a result that the downstream side has not taken; a character in the
// input register otherwise never waits.
module decimal_hex_text_to_integer_unit
  import dht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_char_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] number_value_o,
  output logic        parse_error_o
);

  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        eot_q;
  logic        out_valid_q;
  logic [31:0] value_q;
  logic        error_q;

  dht_char_t   item;
  logic        out_free;
  logic        step;
  logic        load_out;
  logic        in_take;
  logic [31:0] res_value;
  logic        res_error;

  dht_char_decode u_decode (
    .text_char_i   (char_q),
    .end_of_text_i (eot_q),
    .class_o       (item)
  );

  dht_parse_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item),
    .value_o (res_value),
    .error_o (res_error)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && (!item.is_end || out_free);
  assign load_out   = step && item.is_end;
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= load_out;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= text_char_i;
      eot_q  <= end_of_text_i;
    end
    if (load_out) begin
      value_q <= res_value;
      error_q <= res_error;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign number_value_o = value_q;
  assign parse_error_o  = error_q;

endmodule

// ----- hdl/dht_checker.sv -----
// Port-level checks for the text to integer parser, bound to the top level.
`include "assert_macros.svh"

module dht_checker
  import dht_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  text_char_i,
  input logic        end_of_text_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] number_value_o,
  input logic        parse_error_o
);

  logic        end_take;
  logic        out_wait;
  logic [32:0] out_data;

  assign end_take = in_valid_i && !in_stall_o && (end_of_text_i || (text_char_i == CHAR_NUL));
  assign out_wait = out_valid_o && out_stall_i;
  assign out_data = {number_value_o, parse_error_o};

  // input only backs up behind an untaken result
  `DHT_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_wait)

  // a new result follows an accepted end transfer through the input and output registers
  `DHT_ASSERT_IMP(a_result_source, clk_i, rst_ni, $rose(out_valid_o), $past(end_take, 2))

  `DHT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_data))

endmodule

bind decimal_hex_text_to_integer_unit dht_checker u_dht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .text_char_i    (text_char_i),
  .end_of_text_i  (end_of_text_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .number_value_o (number_value_o),
  .parse_error_o  (parse_error_o)
);

// ----- tb/decimal_hex_text_to_integer_unit_test.sv -----
// Self-checking testbench for the decimal/hex text to integer parser.
`timescale 1ns / 100ps

module decimal_hex_text_to_integer_unit_test;
  import dht_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic        error;
  } parse_result_t;

  // Tracks the parser state from accepted characters and checks every result.
  class parsed_value_board;
    logic [31:0] acc;
    logic [3:0]  count;
    logic [1:0]  pos;
    logic        lead_zero;
    logic        hex;
    logic        bad;
    parse_result_t pending_values[$];
    int unsigned failures;
    int unsigned checked;

    function new();
      clear();
      failures = 0;
      checked  = 0;
    endfunction

    function void clear();
      acc       = '0;
      count     = '0;
      pos       = POS_FIRST;
      lead_zero = 1'b0;
      hex       = 1'b0;
      bad       = 1'b0;
    endfunction

    function void note_transfer(logic [7:0] ch, logic eot);
      parse_result_t r;
      logic [3:0]  lim;
      logic [31:0] dig;
      logic        ok;
      if (eot || ch == CHAR_NUL) begin
        lim = hex ? HEX_LIMIT : DEC_LIMIT;
        if (count > lim) begin
          r.value = '0;
          r.error = 1'b1;
        end else begin
          r.value = acc;
          r.error = bad;
        end
        pending_values.push_back(r);
        clear();
        return;
      end
      // prefix letter only right after a leading zero
      if (pos == POS_SECOND && lead_zero && !hex && (ch == CHAR_LO_X || ch == CHAR_UP_X)) begin
        hex   = 1'b1;
        acc   = '0;
        count = '0;
        bad   = 1'b0;
        pos   = POS_LATER;
        return;
      end
      if (count < CNT_MAX) count = count + 4'd1;
      if (!bad) begin
        ok  = 1'b1;
        dig = '0;
        if (ch >= CHAR_0 && ch <= CHAR_9) dig = 32'(ch - CHAR_0);
        else if (hex && ch >= CHAR_LO_A && ch <= CHAR_LO_F) dig = 32'(ch - CHAR_LO_A) + 32'd10;
        else if (hex && ch >= CHAR_UP_A && ch <= CHAR_UP_F) dig = 32'(ch - CHAR_UP_A) + 32'd10;
        else ok = 1'b0;
        if (!ok) bad = 1'b1;
        else if (hex) acc = {acc[27:0], dig[3:0]};
        else acc = acc * 32'd10 + dig;
      end
      if (pos == POS_FIRST) lead_zero = (ch == CHAR_0);
      if (pos < POS_LATER) pos = pos + 2'd1;
    endfunction

    function void check_result(logic [31:0] value, logic error);
      parse_result_t e;
      checked++;
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result value=%h error=%b", $time, value, error);
        failures++;
        return;
      end
      e = pending_values.pop_front();
      if (value !== e.value) begin
        $display("%0t: number_value expected %h actual %h", $time, e.value, value);
        failures++;
      end
      if (error !== e.error) begin
        $display("%0t: parse_error expected %b actual %b", $time, e.error, error);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  text_char_i;
  logic        end_of_text_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] number_value_o;
  logic        parse_error_o;

  parsed_value_board sb = new();
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned transfers;
  int unsigned strings;
  int unsigned quiet_cycles;

  localparam int unsigned QUIET_LIMIT = 5000;

  decimal_hex_text_to_integer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_char_i    (text_char_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .number_value_o (number_value_o),
    .parse_error_o  (parse_error_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(number_value_o, parse_error_o);
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Entered at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [7:0] ch, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_char_i   <= ch;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_transfer(ch, eot);
    transfers++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic [7:0] term, input logic eot);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(term, eot);
    strings++;
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(15);
    if (v < 10) return CHAR_0 + 8'(v);
    return ($urandom_range(1) ? CHAR_LO_A : CHAR_UP_A) + 8'(v - 10);
  endfunction

  task automatic send_random_string();
    logic [7:0] body[$];
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(99);
    if (kind < 40) begin
      len = $urandom_range(12);
      repeat (len) body.push_back(CHAR_0 + 8'($urandom_range(9)));
    end else if (kind < 75) begin
      body.push_back(CHAR_0);
      body.push_back($urandom_range(1) ? CHAR_LO_X : CHAR_UP_X);
      len = $urandom_range(10);
      repeat (len) body.push_back(hex_char());
    end else if (kind < 88) begin
      // well formed, then one character corrupted
      if ($urandom_range(1)) begin
        body.push_back(CHAR_0);
        body.push_back(CHAR_LO_X);
        repeat ($urandom_range(1, 8)) body.push_back(hex_char());
      end else begin
        repeat ($urandom_range(1, 10)) body.push_back(CHAR_0 + 8'($urandom_range(9)));
      end
      body[$urandom_range(body.size() - 1)] = 8'($urandom_range(1, 255));
    end else begin
      repeat ($urandom_range(1, 6)) body.push_back(8'($urandom_range(255)));
    end
    foreach (body[i]) send_item(body[i], 1'b0);
    if ($urandom_range(99) < 70) send_item(8'($urandom_range(255)), 1'b1);
    else send_item(CHAR_NUL, 1'b0);
    strings++;
  endtask

  initial begin
    int unsigned idle_mix[4];
    int unsigned stall_mix[4];
    int unsigned target;
    idle_mix  = '{0, 50, 0, 6};
    stall_mix = '{0, 0, 50, 6};
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    text_char_i   = '0;
    end_of_text_i = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    transfers     = 0;
    strings       = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty string, prefix only, NUL as terminator, decimal wrap, too many hex digits,
    // x out of place with the end character ignored, invalid hex digit
    send_text("", 8'hFF, 1'b1);
    send_text("0x", CHAR_NUL, 1'b1);
    send_text("0XaF", CHAR_NUL, 1'b0);
    send_text("4294967299", 8'h80, 1'b1);
    send_text("0x123456789", CHAR_NUL, 1'b0);
    send_text("1x9", 8'hFF, 1'b1);
    send_text("0xg", 8'h7F, 1'b1);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_mix[p];
      stall_pct     = stall_mix[p];
      target = transfers + 465;
      while (transfers < target) send_random_string();
    end

    in_valid_i <= 1'b0;
    while (sb.pending_values.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Covered %0d character transfers in %0d strings across four idle/stall mixes.",
             transfers, strings);
    $display("Results checked: %0d, mismatches: %0d.", sb.checked, sb.failures);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
